FILE: rtl/trd_pkg.sv
package trd_pkg;

    // record kind codes found in the first byte of a record
    localparam logic [7:0] KIND_ENTRY    = 8'd0;
    localparam logic [7:0] KIND_TAIL     = 8'd1;
    localparam logic [7:0] KIND_EXTENTS  = 8'd2;
    localparam logic [7:0] KIND_META     = 8'd3;
    localparam logic [7:0] KIND_FUNCTION = 8'd4;
    localparam logic [7:0] KIND_CUSTOM   = 8'd5;
    localparam logic [7:0] KIND_TYPED    = 8'd6;

    // framing lengths in bytes
    localparam logic [4:0] HEADER_BYTES = 5'd16;
    localparam logic [4:0] LEN_SHORT    = 5'd8;
    localparam logic [4:0] LEN_MID      = 5'd16;
    localparam logic [4:0] LEN_LONG     = 5'd24;

    // result kind codes
    localparam logic RES_FUNCTION = 1'b0;
    localparam logic RES_SUMMARY  = 1'b1;

    // one result transaction
    typedef struct packed {
        logic        kind;
        logic        is_exit;
        logic [27:0] func_id;
        logic [31:0] timestamp;
        logic [31:0] rec_total;
        logic [31:0] evt_total;
        logic        last;
    } t_result;

    // record length by kind byte
    function automatic logic [4:0] record_length(input logic [7:0] kind);
        logic [4:0] len;
        unique case (kind) inside
            KIND_ENTRY, KIND_TAIL, KIND_META: len = LEN_MID;
            KIND_TYPED:                       len = LEN_LONG;
            default:                          len = LEN_SHORT;
        endcase
        return len;
    endfunction

endpackage

FILE: rtl/trd_out_queue.sv
module trd_out_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_push_cnt,
    input  trd_pkg::t_result  i_entry0,
    input  trd_pkg::t_result  i_entry1,
    output logic              o_room,
    output logic              o_valid,
    output trd_pkg::t_result  o_entry,
    input  logic              i_pop
);

    localparam int DEPTH  = 4;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    trd_pkg::t_result r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             pop_ok;
    logic [PTR_W-1:0] wr_ptr_next;

    assign pop_ok      = i_pop && (r_count != '0);
    assign wr_ptr_next = r_wr_ptr + 1'b1;
    assign o_room      = (r_count <= CNT_W'(DEPTH - 2));
    assign o_valid     = (r_count != '0);
    assign o_entry     = r_mem[r_rd_ptr];

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr + PTR_W'(i_push_cnt);
        n_rd_ptr = pop_ok ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + CNT_W'(i_push_cnt) - CNT_W'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage, up to two writes per cycle
    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_entry0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[wr_ptr_next] <= i_entry1;
        end
    end

    // fill count stays within depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue fill count above depth");

    // pushes only arrive when room was offered
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_cnt != 2'd0) |-> o_room)
        else $error("push without room");

    // pointers stay consistent with the fill count
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("empty queue with unequal pointers");

endmodule

FILE: rtl/trace_record_deframer.sv
// Trace record deframer.
// Input channel: one buffer byte per transaction (i_data_byte), with
// i_end_of_buffer marking the last byte; handshake i_valid / o_ready.
// Output channel: result transactions on o_valid / i_ready, each a
// function record (o_kind 0) or an end-of-buffer summary (o_kind 1).
// The first 16 bytes are skipped as file header; records are framed by
// their kind byte and each complete function record (kind 4) yields one
// result. A byte that ends the buffer adds a summary result.
// A result is registered into the output queue when its byte is accepted.
// Throughput: one byte per cycle; the framer state updates in the cycle
// of acceptance and results go to a four-entry output queue, so the
// input takes bytes while results wait. A byte may cause two results,
// so o_ready drops while fewer than two queue entries are free and the
// output side drains one result per cycle while i_ready is high.
// Reset clears the framer state and counters and empties the queue; the
// framer also returns to its reset state after each end-of-buffer byte.
// A stalled receiver holds the queue head; bytes keep flowing until the
// queue fills, then o_ready stays low until results are taken.
module trace_record_deframer #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_buffer,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_kind,
    output logic        o_is_exit,
    output logic [27:0] o_func_id,
    output logic [31:0] o_timestamp,
    output logic [31:0] o_rec_total,
    output logic [31:0] o_evt_total,
    output logic        o_last
);

    // framer state
    logic                   r_in_header, n_in_header;
    logic [4:0]             r_pos, n_pos;
    logic [7:0]             r_kind, n_kind;
    logic [63:0]            r_word, n_word;
    logic [31:0]            r_skip, n_skip;
    logic [COUNT_WIDTH-1:0] r_rec_cnt, n_rec_cnt;
    logic [COUNT_WIDTH-1:0] r_evt_cnt, n_evt_cnt;

    logic             in_acc;
    logic             func_hit;
    logic [7:0]       kind_eff;
    logic [63:0]      word_sh;
    logic [4:0]       pos_inc;
    logic [31:0]      skip_dec;
    logic [63:0]      rec_ext, evt_ext;
    logic [1:0]       push_cnt;
    logic             q_room;
    trd_pkg::t_result res_func, res_sum, entry0, q_head;

    assign in_acc   = i_valid && o_ready;
    assign o_ready  = q_room;
    assign kind_eff = (r_pos == 5'd0) ? i_data_byte : r_kind;
    assign word_sh  = {i_data_byte, r_word[63:8]};
    assign pos_inc  = r_pos + 5'd1;
    assign skip_dec = r_skip - 32'd1;

    // next state for one accepted byte
    always_comb begin
        n_in_header = r_in_header;
        n_pos       = r_pos;
        n_kind      = r_kind;
        n_word      = r_word;
        n_skip      = r_skip;
        n_rec_cnt   = r_rec_cnt;
        n_evt_cnt   = r_evt_cnt;
        func_hit    = 1'b0;
        if (r_in_header) begin
            if (pos_inc >= trd_pkg::HEADER_BYTES) begin
                n_in_header = 1'b0;
                n_pos       = 5'd0;
            end else begin
                n_pos = pos_inc;
            end
        end else if (r_kind == trd_pkg::KIND_CUSTOM && r_pos == trd_pkg::LEN_MID
                     && r_skip != 32'd0) begin
            // skipping custom event payload
            n_skip = skip_dec;
            if (skip_dec == 32'd0) begin
                n_pos = 5'd0;
            end
        end else begin
            n_kind = kind_eff;
            n_word = word_sh;
            n_pos  = pos_inc;
            if (kind_eff == trd_pkg::KIND_CUSTOM) begin
                if (pos_inc == trd_pkg::LEN_MID) begin
                    n_evt_cnt = (r_evt_cnt == '1) ? r_evt_cnt : r_evt_cnt + 1'b1;
                    n_skip    = word_sh[31:0];
                    if (word_sh[31:0] == 32'd0) begin
                        n_pos = 5'd0;
                    end
                end
            end else if (pos_inc >= trd_pkg::record_length(kind_eff)) begin
                n_pos = 5'd0;
                if (kind_eff == trd_pkg::KIND_FUNCTION) begin
                    n_rec_cnt = (r_rec_cnt == '1) ? r_rec_cnt : r_rec_cnt + 1'b1;
                    func_hit  = 1'b1;
                end
            end
        end
    end

    // result assembly
    assign rec_ext = 64'(n_rec_cnt);
    assign evt_ext = 64'(n_evt_cnt);

    always_comb begin
        res_func.kind      = trd_pkg::RES_FUNCTION;
        res_func.is_exit   = word_sh[0];
        res_func.func_id   = word_sh[28:1];
        res_func.timestamp = word_sh[63:32];
        res_func.rec_total = rec_ext[31:0];
        res_func.evt_total = evt_ext[31:0];
        res_func.last      = !i_end_of_buffer;

        res_sum.kind       = trd_pkg::RES_SUMMARY;
        res_sum.is_exit    = 1'b0;
        res_sum.func_id    = 28'd0;
        res_sum.timestamp  = 32'd0;
        res_sum.rec_total  = rec_ext[31:0];
        res_sum.evt_total  = evt_ext[31:0];
        res_sum.last       = 1'b1;

        entry0   = func_hit ? res_func : res_sum;
        push_cnt = in_acc ? (2'(func_hit) + 2'(i_end_of_buffer)) : 2'd0;
    end

    // state registers, cleared again at end of buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (in_acc && i_end_of_buffer)) begin
            r_in_header <= 1'b1;
            r_pos       <= 5'd0;
            r_kind      <= 8'd0;
            r_word      <= 64'd0;
            r_skip      <= 32'd0;
            r_rec_cnt   <= '0;
            r_evt_cnt   <= '0;
        end else if (in_acc) begin
            r_in_header <= n_in_header;
            r_pos       <= n_pos;
            r_kind      <= n_kind;
            r_word      <= n_word;
            r_skip      <= n_skip;
            r_rec_cnt   <= n_rec_cnt;
            r_evt_cnt   <= n_evt_cnt;
        end
    end

    // output queue
    trd_out_queue u_out_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_entry0   (entry0),
        .i_entry1   (res_sum),
        .o_room     (q_room),
        .o_valid    (o_valid),
        .o_entry    (q_head),
        .i_pop      (i_ready)
    );

    assign o_kind      = q_head.kind;
    assign o_is_exit   = q_head.is_exit;
    assign o_func_id   = q_head.func_id;
    assign o_timestamp = q_head.timestamp;
    assign o_rec_total = q_head.rec_total;
    assign o_evt_total = q_head.evt_total;
    assign o_last      = q_head.last;

    // end of buffer returns the framer to its reset state
    a_eob_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_end_of_buffer) |=> (r_in_header && r_pos == 5'd0
                                         && r_rec_cnt == '0 && r_evt_cnt == '0))
        else $error("framer not cleared after end of buffer");

    // header position stays below header length
    a_header_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_header |-> (r_pos < trd_pkg::HEADER_BYTES))
        else $error("header position out of range");

    // record position never passes the longest record
    a_record_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_header |-> (r_pos <= trd_pkg::LEN_LONG))
        else $error("record position out of range");

    // a function result never follows a byte still in the header
    a_func_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        func_hit |-> !r_in_header)
        else $error("function record raised during header");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 8;
    localparam int STREAM_BYTES  = 900;
    localparam int HOLD_CYCLES   = 80;
    localparam int DRAIN_CYCLES  = 20;
    localparam int LIMIT_CYCLES  = 200000;
    localparam int DENSE_RECORDS = 12;

    // traffic shaping phases
    localparam int PH_SLOW_SINK   = 0;
    localparam int PH_SLOW_SOURCE = 1;
    localparam int PH_FULL_RATE   = 2;

    // expected result tracking for the deframer
    class trace_scoreboard;
        bit               in_header;
        logic [4:0]       byte_pos;
        logic [7:0]       rec_kind;
        logic [63:0]      rec_word;
        logic [31:0]      payload_left;
        logic [31:0]      func_count;
        logic [31:0]      custom_count;
        trd_pkg::t_result due_results[$];
        int               failures;

        function new();
            clear();
            failures = 0;
        endfunction

        function void clear();
            in_header    = 1'b1;
            byte_pos     = '0;
            rec_kind     = '0;
            rec_word     = '0;
            payload_left = '0;
            func_count   = '0;
            custom_count = '0;
        endfunction

        // advance the framer by one accepted byte and queue its results
        function void absorb_byte(logic [7:0] b, logic eob);
            trd_pkg::t_result r;
            logic [4:0]       frame_len;
            if (in_header) begin
                byte_pos++;
                if (byte_pos >= trd_pkg::HEADER_BYTES) begin
                    in_header = 1'b0;
                    byte_pos  = '0;
                end
            end else if (rec_kind == trd_pkg::KIND_CUSTOM && byte_pos == trd_pkg::LEN_MID
                         && payload_left != 0) begin
                // skipping custom event payload
                payload_left--;
                if (payload_left == 0) byte_pos = '0;
            end else begin
                if (byte_pos == 0) rec_kind = b;
                rec_word = {b, rec_word[63:8]};
                byte_pos++;
                case (rec_kind) inside
                    trd_pkg::KIND_ENTRY, trd_pkg::KIND_TAIL, trd_pkg::KIND_META:
                        frame_len = trd_pkg::LEN_MID;
                    trd_pkg::KIND_TYPED: frame_len = trd_pkg::LEN_LONG;
                    default: frame_len = trd_pkg::LEN_SHORT;
                endcase
                if (rec_kind == trd_pkg::KIND_CUSTOM) begin
                    // counted on its 16th byte, payload length from second word
                    if (byte_pos == trd_pkg::LEN_MID) begin
                        if (custom_count != '1) custom_count++;
                        payload_left = rec_word[31:0];
                        if (payload_left == 0) byte_pos = '0;
                    end
                end else if (byte_pos >= frame_len) begin
                    byte_pos = '0;
                    if (rec_kind == trd_pkg::KIND_FUNCTION) begin
                        if (func_count != '1) func_count++;
                        r.kind      = trd_pkg::RES_FUNCTION;
                        r.is_exit   = rec_word[0];
                        r.func_id   = rec_word[28:1];
                        r.timestamp = rec_word[63:32];
                        r.rec_total = func_count;
                        r.evt_total = custom_count;
                        r.last      = !eob;
                        due_results = {due_results, r};
                    end
                end
            end
            // end of buffer adds a summary and returns to reset state
            if (eob) begin
                r.kind      = trd_pkg::RES_SUMMARY;
                r.is_exit   = 1'b0;
                r.func_id   = '0;
                r.timestamp = '0;
                r.rec_total = func_count;
                r.evt_total = custom_count;
                r.last      = 1'b1;
                due_results = {due_results, r};
                clear();
            end
        endfunction

        // compare one output transaction against the oldest expectation
        function void check_result(trd_pkg::t_result got);
            trd_pkg::t_result want;
            if (due_results.size() == 0) begin
                $error("unexpected result: kind %0d func_id %h timestamp %h",
                       got.kind, got.func_id, got.timestamp);
                failures++;
                return;
            end
            want = due_results.pop_front();
            if (got.kind !== want.kind) begin
                $error("kind: expected %0d, actual %0d", want.kind, got.kind);
                failures++;
            end
            if (got.is_exit !== want.is_exit) begin
                $error("is_exit: expected %0d, actual %0d", want.is_exit, got.is_exit);
                failures++;
            end
            if (got.func_id !== want.func_id) begin
                $error("func_id: expected %h, actual %h", want.func_id, got.func_id);
                failures++;
            end
            if (got.timestamp !== want.timestamp) begin
                $error("timestamp: expected %h, actual %h", want.timestamp, got.timestamp);
                failures++;
            end
            if (got.rec_total !== want.rec_total) begin
                $error("rec_total: expected %0d, actual %0d",
                       want.rec_total, got.rec_total);
                failures++;
            end
            if (got.evt_total !== want.evt_total) begin
                $error("evt_total: expected %0d, actual %0d",
                       want.evt_total, got.evt_total);
                failures++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, actual %0d", want.last, got.last);
                failures++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        i_valid         = 1'b0;
    logic [7:0]  i_data_byte     = '0;
    logic        i_end_of_buffer = 1'b0;
    logic        i_ready         = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic        o_kind;
    logic        o_is_exit;
    logic [27:0] o_func_id;
    logic [31:0] o_timestamp;
    logic [31:0] o_rec_total;
    logic [31:0] o_evt_total;
    logic        o_last;

    trace_scoreboard sb = new();

    logic [7:0] frame[$];
    int         phase;
    int         send_idle_pct;
    int         recv_idle_pct;
    int         bytes_sent;
    int         cycles;
    int         hold_left;
    bit         hold_request;
    bit         hold_taken;

    trace_record_deframer u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_data_byte     (i_data_byte),
        .i_end_of_buffer (i_end_of_buffer),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_kind          (o_kind),
        .o_is_exit       (o_is_exit),
        .o_func_id       (o_func_id),
        .o_timestamp     (o_timestamp),
        .o_rec_total     (o_rec_total),
        .o_evt_total     (o_evt_total),
        .o_last          (o_last)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // run limit
    initial begin
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // output side: check accepted results, then pick next ready
    initial begin
        hold_left  = 0;
        hold_taken = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                sb.check_result('{o_kind, o_is_exit, o_func_id, o_timestamp,
                                  o_rec_total, o_evt_total, o_last});
            end
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    task automatic set_phase(input int p);
        phase = p;
        case (p)
            PH_SLOW_SINK: begin
                send_idle_pct = 6;
                recv_idle_pct = 76;
            end
            PH_SLOW_SOURCE: begin
                send_idle_pct = 76;
                recv_idle_pct = 6;
            end
            default: begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    // offer one byte, hold it until the transaction completes
    task automatic send_byte(input logic [7:0] b, input logic eob);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_data_byte     <= b;
        i_end_of_buffer <= eob;
        do @(posedge i_clk); while (!o_ready);
        sb.absorb_byte(b, eob);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1);
    endtask

    // stop offering until every expected result has been taken
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.due_results.size() != 0);
    endtask

    // build one trace buffer: header, records, optional truncation
    task automatic build_frame(input bit dense);
        int          pick;
        int          n_records;
        int          body;
        int          tail;
        int          keep;
        logic [7:0]  kind;
        logic [31:0] skip_len;
        bit          cut_short;
        frame.delete();
        cut_short = 1'b0;
        repeat (trd_pkg::HEADER_BYTES) frame = {frame, 8'($urandom_range(0, 255))};
        n_records = dense ? DENSE_RECORDS : $urandom_range(0, 8);
        for (int r = 0; r < n_records && !cut_short; r++) begin
            pick = $urandom_range(0, 99);
            if (dense || pick < 45) kind = trd_pkg::KIND_FUNCTION;
            else if (pick < 60) kind = trd_pkg::KIND_CUSTOM;
            else if (pick < 67) kind = trd_pkg::KIND_ENTRY;
            else if (pick < 72) kind = trd_pkg::KIND_TAIL;
            else if (pick < 77) kind = trd_pkg::KIND_EXTENTS;
            else if (pick < 82) kind = trd_pkg::KIND_META;
            else if (pick < 88) kind = trd_pkg::KIND_TYPED;
            else kind = 8'($urandom_range(int'(trd_pkg::KIND_TYPED) + 1, 255));
            frame = {frame, kind};
            case (kind) inside
                trd_pkg::KIND_ENTRY, trd_pkg::KIND_TAIL, trd_pkg::KIND_META,
                trd_pkg::KIND_CUSTOM: body = trd_pkg::LEN_MID - 1;
                trd_pkg::KIND_TYPED: body = trd_pkg::LEN_LONG - 1;
                default: body = trd_pkg::LEN_SHORT - 1;
            endcase
            if (kind == trd_pkg::KIND_CUSTOM) begin
                // huge payload length: buffer ends inside the payload
                if ($urandom_range(0, 7) == 0) begin
                    skip_len  = $urandom | 32'h100;
                    tail      = $urandom_range(0, 6);
                    cut_short = 1'b1;
                end else begin
                    skip_len = $urandom_range(0, 12);
                    tail     = int'(skip_len);
                end
                for (int i = 1; i <= body; i++) begin
                    if (i >= 8 && i < 12) frame = {frame, skip_len[8*(i-8) +: 8]};
                    else frame = {frame, 8'($urandom_range(0, 255))};
                end
                repeat (tail) frame = {frame, 8'($urandom_range(0, 255))};
            end else begin
                repeat (body) frame = {frame, 8'($urandom_range(0, 255))};
            end
        end
        // sometimes end the buffer at an arbitrary byte
        if (!dense && !cut_short && $urandom_range(0, 3) == 0) begin
            keep = $urandom_range(1, frame.size());
            while (frame.size() > keep) void'(frame.pop_back());
        end
    endtask

    // main stimulus
    initial begin
        bytes_sent   = 0;
        hold_request = 1'b0;
        set_phase(PH_SLOW_SINK);
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // buffer that ends on its first header byte
        frame.delete();
        frame = {frame, 8'h00};
        send_frame();

        // full header, then a function record whose last byte ends the buffer
        frame.delete();
        for (int i = 0; i < trd_pkg::HEADER_BYTES; i++) begin
            frame = {frame, (i % 2) ? 8'hFF : 8'h00};
        end
        frame = {frame, trd_pkg::KIND_FUNCTION};
        repeat (trd_pkg::LEN_SHORT - 1) frame = {frame, 8'hFF};
        send_frame();
        wait_drained();

        // random buffers across the traffic phases
        while (bytes_sent < STREAM_BYTES) begin
            if (bytes_sent >= 2 * STREAM_BYTES / 3 && phase != PH_FULL_RATE) begin
                wait_drained();
                set_phase(PH_FULL_RATE);
                hold_request = 1'b1;
                build_frame(1'b1);
                send_frame();
            end else if (bytes_sent >= STREAM_BYTES / 3 && phase == PH_SLOW_SINK) begin
                wait_drained();
                set_phase(PH_SLOW_SOURCE);
            end
            build_frame(1'b0);
            send_frame();
        end

        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.due_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.failures == 0 && sb.due_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
